// ===== rtl/eapm_pkg.sv =====
// ----------------------------------------------------------------------------
// eapm_pkg
// Shared widths, pipeline depths and fixed-point helpers for the Euler angle
// to pose matrix block.
// ----------------------------------------------------------------------------
package eapm_pkg;

    localparam int POS_W   = 32;   // Q16.16 translation
    localparam int ANGLE_W = 16;   // binary angle, 65536 counts per turn
    localparam int ENTRY_W = 16;   // Q1.15 matrix entry
    localparam int TRIG_W  = 17;   // signed sine/cosine, 1.0 = 32768

    // sine/cosine lane: angle reduce, x, x squared, four Horner slots of
    // three stages each, final round and quadrant map
    localparam int HORNER_SLOTS = 4;
    localparam int SIN_STEPS    = 3;
    localparam int LANE_DEPTH   = 3 + 3 * HORNER_SLOTS;
    // matrix: pair products, triple products, sum and round
    localparam int PIPE_DEPTH   = LANE_DEPTH + 3;

    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [32:0] ANG_SCALE = 33'd6746518852;   // 2*pi in Q30, shifted

    // Horner divisors and their reciprocals in Q31 (floor)
    localparam logic [5:0]  K_COS [HORNER_SLOTS] = '{6'd56, 6'd30, 6'd12, 6'd2};
    localparam logic [5:0]  K_SIN [SIN_STEPS]    = '{6'd42, 6'd20, 6'd6};
    localparam logic [30:0] M_COS [HORNER_SLOTS] = '{
        31'((64'd1 << 31) / 64'd56), 31'((64'd1 << 31) / 64'd30),
        31'((64'd1 << 31) / 64'd12), 31'((64'd1 << 31) / 64'd2)};
    localparam logic [30:0] M_SIN [SIN_STEPS] = '{
        31'((64'd1 << 31) / 64'd42), 31'((64'd1 << 31) / 64'd20),
        31'((64'd1 << 31) / 64'd6)};

    // quadrant codes of a binary angle
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Q45 to Q15: round half up, then clamp to the Q1.15 range
    function automatic logic signed [ENTRY_W-1:0] round_q15(input logic signed [48:0] v);
        logic signed [48:0] w;
        logic signed [ENTRY_W-1:0] r;
        w = (v + 49'sd536870912) >>> 30;
        if (w > 49'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (w < -49'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = w[ENTRY_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/eapm_sincos.sv =====
// ----------------------------------------------------------------------------
// eapm_sincos
// Pipelined sine and cosine of one binary angle: octant reduction, Taylor
// series in Horner form with constant divisions by reciprocal multiply and
// correction, quadrant mapping.
// ----------------------------------------------------------------------------
module eapm_sincos (
    input  logic                                 clk,
    input  logic [eapm_pkg::ANGLE_W-1:0]         angle,
    output logic signed [eapm_pkg::TRIG_W-1:0]   sin_val,
    output logic signed [eapm_pkg::TRIG_W-1:0]   cos_val
);
    import eapm_pkg::*;

    typedef struct packed {
        logic [29:0] x;
        logic [29:0] x2;
        logic [1:0]  quad;
        logic        swap;
    } side_t;

    // stage 0: octant reduction and scaling to radians
    logic [13:0] r_oct;
    logic        swap_now;
    logic [13:0] a_oct;
    logic [46:0] x_prod;
    side_t       s0_reg;

    assign r_oct    = angle[13:0];
    assign swap_now = r_oct > 14'd8192;
    assign a_oct    = swap_now ? 14'(15'd16384 - {1'b0, r_oct}) : r_oct;
    assign x_prod   = 47'(a_oct) * 47'(ANG_SCALE);

    always_ff @(posedge clk)
    begin
        s0_reg.x    <= x_prod[45:16];
        s0_reg.x2   <= '0;
        s0_reg.quad <= angle[15:14];
        s0_reg.swap <= swap_now;
    end

    // stage 1: x squared
    logic [59:0] xx_prod;
    side_t       s1_reg;

    assign xx_prod = 60'(s0_reg.x) * 60'(s0_reg.x);

    always_ff @(posedge clk)
    begin
        s1_reg.x    <= s0_reg.x;
        s1_reg.x2   <= xx_prod[59:30];
        s1_reg.quad <= s0_reg.quad;
        s1_reg.swap <= s0_reg.swap;
    end

    // Horner slots: multiply, reciprocal multiply, correct and subtract
    side_t       sa_reg [HORNER_SLOTS];
    side_t       sb_reg [HORNER_SLOTS];
    side_t       sc_reg [HORNER_SLOTS];
    logic [29:0] pc_a_reg [HORNER_SLOTS];
    logic [29:0] ps_a_reg [HORNER_SLOTS];
    logic [29:0] pc_b_reg [HORNER_SLOTS];
    logic [29:0] ps_b_reg [HORNER_SLOTS];
    logic [29:0] qc_b_reg [HORNER_SLOTS];
    logic [29:0] qs_b_reg [HORNER_SLOTS];
    logic [30:0] tc_reg   [HORNER_SLOTS];
    logic [30:0] ts_reg   [HORNER_SLOTS];

    for (genvar i = 0; i < HORNER_SLOTS; i++)
    begin : g_slot
        side_t       side_in;
        logic [30:0] tc_in;
        logic [30:0] ts_in;
        logic [29:0] ms_op;
        logic [60:0] mc_prod;
        logic [60:0] ms_prod;
        logic [60:0] rc_prod;
        logic [36:0] rem_c;
        logic [29:0] qc_fix;

        if (i == 0)
        begin : g_first
            assign side_in = s1_reg;
            assign tc_in   = Q30_ONE;
            assign ts_in   = Q30_ONE;
        end
        else
        begin : g_next
            assign side_in = sc_reg[i-1];
            assign tc_in   = tc_reg[i-1];
            assign ts_in   = ts_reg[i-1];
        end

        // stage A: product with the running term
        assign ms_op   = (i < SIN_STEPS) ? side_in.x2 : side_in.x;
        assign mc_prod = 61'(side_in.x2) * 61'(tc_in);
        assign ms_prod = 61'(ms_op) * 61'(ts_in);

        always_ff @(posedge clk)
        begin
            sa_reg[i]   <= side_in;
            pc_a_reg[i] <= mc_prod[59:30];
            ps_a_reg[i] <= ms_prod[59:30];
        end

        // stage B: quotient estimate, low by at most one
        assign rc_prod = 61'(pc_a_reg[i]) * 61'(M_COS[i]);

        always_ff @(posedge clk)
        begin
            sb_reg[i]   <= sa_reg[i];
            pc_b_reg[i] <= pc_a_reg[i];
            ps_b_reg[i] <= ps_a_reg[i];
            qc_b_reg[i] <= rc_prod[60:31];
        end

        // stage C: quotient correction and next term
        assign rem_c  = 37'(pc_b_reg[i]) - 37'(qc_b_reg[i]) * 37'(K_COS[i]);
        assign qc_fix = qc_b_reg[i] + 30'(rem_c >= 37'(K_COS[i]));

        always_ff @(posedge clk)
        begin
            sc_reg[i] <= sb_reg[i];
            tc_reg[i] <= Q30_ONE - 31'(qc_fix);
        end

        if (i < SIN_STEPS)
        begin : g_sin_div
            logic [60:0] rs_prod;
            logic [36:0] rem_s;
            logic [29:0] qs_fix;

            assign rs_prod = 61'(ps_a_reg[i]) * 61'(M_SIN[i]);
            assign rem_s   = 37'(ps_b_reg[i]) - 37'(qs_b_reg[i]) * 37'(K_SIN[i]);
            assign qs_fix  = qs_b_reg[i] + 30'(rem_s >= 37'(K_SIN[i]));

            always_ff @(posedge clk)
            begin
                qs_b_reg[i] <= rs_prod[60:31];
                ts_reg[i]   <= Q30_ONE - 31'(qs_fix);
            end
        end
        else
        begin : g_sin_pass
            // last slot holds x * t, the sine before rounding
            always_ff @(posedge clk)
            begin
                qs_b_reg[i] <= '0;
                ts_reg[i]   <= {1'b0, ps_b_reg[i]};
            end
        end
    end

    // final stage: round to 1.0 = 32768, undo octant and quadrant
    side_t             side_f;
    logic [31:0]       s_sum;
    logic [31:0]       c_sum;
    logic [15:0]       s_poly;
    logic [15:0]       c_poly;
    logic signed [TRIG_W-1:0] s0;
    logic signed [TRIG_W-1:0] c0;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [TRIG_W-1:0] cos_next;

    assign side_f = sc_reg[HORNER_SLOTS-1];
    assign s_sum  = 32'(ts_reg[HORNER_SLOTS-1]) + 32'd16384;
    assign c_sum  = 32'(tc_reg[HORNER_SLOTS-1]) + 32'd16384;
    assign s_poly = s_sum[30:15];
    assign c_poly = c_sum[30:15];
    assign s0     = signed'({1'b0, side_f.swap ? c_poly : s_poly});
    assign c0     = signed'({1'b0, side_f.swap ? s_poly : c_poly});

    always_comb
    begin
        case (side_f.quad)
            QUAD_0:
            begin
                sin_next = s0;
                cos_next = c0;
            end
            QUAD_1:
            begin
                sin_next = c0;
                cos_next = -s0;
            end
            QUAD_2:
            begin
                sin_next = -s0;
                cos_next = -c0;
            end
            default:
            begin
                sin_next = -c0;
                cos_next = s0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== rtl/euler_angles_to_pose_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_angles_to_pose_matrix
// Pose from translation and three binary angles: R = Rx(psi)*Ry(theta)*Rz(phi)
// as nine Q1.15 entries, translation passed through.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive pos_x/y/z and angle_theta/psi/phi with start high.
//   A request is taken at a rising edge where start is high and busy is low;
//   busy is always low, so one request can be taken every cycle.
//   Result channel: done is high for exactly one cycle with r00..r22 and
//   out_x/y/z. Results come back in request order, one per request.
//   Pipeline: the three sine/cosine lanes (octant reduction, x squared,
//   four Horner slots of multiply, reciprocal multiply and correction,
//   quadrant map), then pair products, triple products, sum and round.
//   Throughput: one request per cycle, set by the fully pipelined lanes.
//   Reset (rst_n low, asynchronous) clears the valid bits: requests in
//   flight are dropped and done stays low until new requests emerge.
//   The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
module euler_angles_to_pose_matrix (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [eapm_pkg::POS_W-1:0]     pos_x,
    input  logic signed [eapm_pkg::POS_W-1:0]     pos_y,
    input  logic signed [eapm_pkg::POS_W-1:0]     pos_z,
    input  logic signed [eapm_pkg::ANGLE_W-1:0]   angle_theta,
    input  logic signed [eapm_pkg::ANGLE_W-1:0]   angle_psi,
    input  logic signed [eapm_pkg::ANGLE_W-1:0]   angle_phi,
    output logic                                  done,
    output logic signed [eapm_pkg::ENTRY_W-1:0]   r00,
    output logic signed [eapm_pkg::ENTRY_W-1:0]   r01,
    output logic signed [eapm_pkg::ENTRY_W-1:0]   r02,
    output logic signed [eapm_pkg::ENTRY_W-1:0]   r10,
    output logic signed [eapm_pkg::ENTRY_W-1:0]   r11,
    output logic signed [eapm_pkg::ENTRY_W-1:0]   r12,
    output logic signed [eapm_pkg::ENTRY_W-1:0]   r20,
    output logic signed [eapm_pkg::ENTRY_W-1:0]   r21,
    output logic signed [eapm_pkg::ENTRY_W-1:0]   r22,
    output logic signed [eapm_pkg::POS_W-1:0]     out_x,
    output logic signed [eapm_pkg::POS_W-1:0]     out_y,
    output logic signed [eapm_pkg::POS_W-1:0]     out_z
);
    import eapm_pkg::*;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits and translation travel alongside the arithmetic
    logic                    vld_reg [PIPE_DEPTH];
    logic signed [POS_W-1:0] px_reg  [PIPE_DEPTH];
    logic signed [POS_W-1:0] py_reg  [PIPE_DEPTH];
    logic signed [POS_W-1:0] pz_reg  [PIPE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg[0] <= pos_x;
        py_reg[0] <= pos_y;
        pz_reg[0] <= pos_z;
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            px_reg[i] <= px_reg[i-1];
            py_reg[i] <= py_reg[i-1];
            pz_reg[i] <= pz_reg[i-1];
        end
    end

    // sine/cosine lanes
    logic signed [TRIG_W-1:0] st, ct, sp, cp, sf, cf;

    eapm_sincos u_theta (.clk(clk), .angle(angle_theta), .sin_val(st), .cos_val(ct));
    eapm_sincos u_psi   (.clk(clk), .angle(angle_psi),   .sin_val(sp), .cos_val(cp));
    eapm_sincos u_phi   (.clk(clk), .angle(angle_phi),   .sin_val(sf), .cos_val(cf));

    // stage M1: pair products
    logic signed [33:0] ctcf_reg, ctsf_reg, cpsf_reg, cpcf_reg, spct_reg;
    logic signed [33:0] spsf_reg, spcf_reg, cpct_reg, spst_reg, cpst_reg;
    logic signed [TRIG_W-1:0] st1_reg, sf1_reg, cf1_reg;

    always_ff @(posedge clk)
    begin
        ctcf_reg <= 34'(ct) * 34'(cf);
        ctsf_reg <= 34'(ct) * 34'(sf);
        cpsf_reg <= 34'(cp) * 34'(sf);
        cpcf_reg <= 34'(cp) * 34'(cf);
        spct_reg <= 34'(sp) * 34'(ct);
        spsf_reg <= 34'(sp) * 34'(sf);
        spcf_reg <= 34'(sp) * 34'(cf);
        cpct_reg <= 34'(cp) * 34'(ct);
        spst_reg <= 34'(sp) * 34'(st);
        cpst_reg <= 34'(cp) * 34'(st);
        st1_reg  <= st;
        sf1_reg  <= sf;
        cf1_reg  <= cf;
    end

    // stage M2: triple products
    logic signed [50:0] spstcf_reg, spstsf_reg, cpstcf_reg, cpstsf_reg;
    logic signed [33:0] ctcf2_reg, ctsf2_reg, cpsf2_reg, cpcf2_reg, spct2_reg;
    logic signed [33:0] spsf2_reg, spcf2_reg, cpct2_reg;
    logic signed [TRIG_W-1:0] st2_reg;

    always_ff @(posedge clk)
    begin
        spstcf_reg <= 51'(spst_reg) * 51'(cf1_reg);
        spstsf_reg <= 51'(spst_reg) * 51'(sf1_reg);
        cpstcf_reg <= 51'(cpst_reg) * 51'(cf1_reg);
        cpstsf_reg <= 51'(cpst_reg) * 51'(sf1_reg);
        ctcf2_reg  <= ctcf_reg;
        ctsf2_reg  <= ctsf_reg;
        cpsf2_reg  <= cpsf_reg;
        cpcf2_reg  <= cpcf_reg;
        spct2_reg  <= spct_reg;
        spsf2_reg  <= spsf_reg;
        spcf2_reg  <= spcf_reg;
        cpct2_reg  <= cpct_reg;
        st2_reg    <= st1_reg;
    end

    // stage M3: Q45 sums, round and clamp
    logic signed [48:0] v00, v01, v02, v10, v11, v12, v20, v21, v22;

    assign v00 = 49'(ctcf2_reg) <<< 15;
    assign v01 = 49'(ctsf2_reg) <<< 15;
    assign v02 = -(49'(st2_reg) <<< 30);
    assign v10 = -(49'(cpsf2_reg) <<< 15) + 49'(spstcf_reg);
    assign v11 = (49'(cpcf2_reg) <<< 15) + 49'(spstsf_reg);
    assign v12 = 49'(spct2_reg) <<< 15;
    assign v20 = (49'(spsf2_reg) <<< 15) + 49'(cpstcf_reg);
    assign v21 = -(49'(spcf2_reg) <<< 15) + 49'(cpstsf_reg);
    assign v22 = 49'(cpct2_reg) <<< 15;

    logic signed [ENTRY_W-1:0] r00_reg, r01_reg, r02_reg, r10_reg, r11_reg;
    logic signed [ENTRY_W-1:0] r12_reg, r20_reg, r21_reg, r22_reg;

    always_ff @(posedge clk)
    begin
        r00_reg <= round_q15(v00);
        r01_reg <= round_q15(v01);
        r02_reg <= round_q15(v02);
        r10_reg <= round_q15(v10);
        r11_reg <= round_q15(v11);
        r12_reg <= round_q15(v12);
        r20_reg <= round_q15(v20);
        r21_reg <= round_q15(v21);
        r22_reg <= round_q15(v22);
    end

    assign done  = vld_reg[PIPE_DEPTH-1];
    assign r00   = r00_reg;
    assign r01   = r01_reg;
    assign r02   = r02_reg;
    assign r10   = r10_reg;
    assign r11   = r11_reg;
    assign r12   = r12_reg;
    assign r20   = r20_reg;
    assign r21   = r21_reg;
    assign r22   = r22_reg;
    assign out_x = px_reg[PIPE_DEPTH-1];
    assign out_y = py_reg[PIPE_DEPTH-1];
    assign out_z = pz_reg[PIPE_DEPTH-1];

endmodule

// ===== rtl/eapm_checker.sv =====
// ----------------------------------------------------------------------------
// eapm_checker
// Port-level checks: request/result pairing, translation pass-through and
// the identity pose.
// ----------------------------------------------------------------------------
module eapm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic signed [eapm_pkg::POS_W-1:0]    pos_x,
    input logic signed [eapm_pkg::POS_W-1:0]    pos_z,
    input logic signed [eapm_pkg::ANGLE_W-1:0]  angle_theta,
    input logic signed [eapm_pkg::ANGLE_W-1:0]  angle_psi,
    input logic signed [eapm_pkg::ANGLE_W-1:0]  angle_phi,
    input logic                                 done,
    input logic signed [eapm_pkg::ENTRY_W-1:0]  r00,
    input logic signed [eapm_pkg::ENTRY_W-1:0]  r01,
    input logic signed [eapm_pkg::POS_W-1:0]    out_x,
    input logic signed [eapm_pkg::POS_W-1:0]    out_z
);
    import eapm_pkg::*;

    // the pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // every result traces back to a request a fixed latency earlier
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_DEPTH))
        else $error("result without request");

    // translation arrives with its own request
    a_pos_through: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_x == $past(pos_x, PIPE_DEPTH)) && (out_z == $past(pos_z, PIPE_DEPTH)))
        else $error("translation mismatch");

    // zero angles: r00 of the identity is +1 clamped, r01 is zero
    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past((angle_theta == 0) && (angle_psi == 0) && (angle_phi == 0), PIPE_DEPTH)
        |-> (r00 == 16'sh7FFF) && (r01 == 16'sh0000))
        else $error("identity pose wrong");

endmodule

bind euler_angles_to_pose_matrix eapm_checker u_eapm_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .pos_x(pos_x), .pos_z(pos_z),
    .angle_theta(angle_theta), .angle_psi(angle_psi), .angle_phi(angle_phi),
    .done(done), .r00(r00), .r01(r01), .out_x(out_x), .out_z(out_z)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for euler_angles_to_pose_matrix: directed and random
// poses are fed through the command port, and each returned matrix and
// translation is compared with a local fixed-point prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
    logic [15:0] rot [9];
    logic [31:0] pos [3];
} pose_t;

class pose_scoreboard;

    pose_t pending[$];
    int    mismatches;

    // octant polynomial pair, both rounded to 1.0 = 32768
    static function void octant_trig(longint x, longint x2, output longint ps,
                                     output longint pc);
        longint t;
        t = 64'sd1073741824 - x2 / 42;
        t = 64'sd1073741824 - ((x2 * t) >>> 30) / 20;
        t = 64'sd1073741824 - ((x2 * t) >>> 30) / 6;
        ps = (((x * t) >>> 30) + 16384) >>> 15;
        t = 64'sd1073741824 - x2 / 56;
        t = 64'sd1073741824 - ((x2 * t) >>> 30) / 30;
        t = 64'sd1073741824 - ((x2 * t) >>> 30) / 12;
        t = 64'sd1073741824 - ((x2 * t) >>> 30) / 2;
        pc = (t + 16384) >>> 15;
    endfunction

    static function void angle_trig(logic [15:0] u, output longint s, output longint c);
        longint a, x, x2, ps, pc, s0, c0;
        logic [13:0] r;
        r = u[13:0];
        a = (r > 8192) ? 16384 - r : r;
        x = (a * 64'sd6746518852) >>> 16;
        x2 = (x * x) >>> 30;
        octant_trig(x, x2, ps, pc);
        s0 = (r > 8192) ? pc : ps;
        c0 = (r > 8192) ? ps : pc;
        case (u[15:14])
            eapm_pkg::QUAD_0: begin s = s0;  c = c0;  end
            eapm_pkg::QUAD_1: begin s = c0;  c = -s0; end
            eapm_pkg::QUAD_2: begin s = -s0; c = -c0; end
            default:          begin s = -c0; c = s0;  end
        endcase
    endfunction

    // Q45 to Q15, half up, clamp
    static function logic [15:0] q45_to_q15(longint v);
        longint w;
        w = (v + 64'sd536870912) >>> 30;
        if (w > 32767) w = 32767;
        if (w < -32768) w = -32768;
        return w[15:0];
    endfunction

    function void note_request(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [15:0] th, logic [15:0] ps, logic [15:0] ph);
        pose_t e;
        longint st, ct, sp, cp, sf, cf;
        angle_trig(th, st, ct);
        angle_trig(ps, sp, cp);
        angle_trig(ph, sf, cf);
        e.rot[0] = q45_to_q15(ct * cf * 32768);
        e.rot[1] = q45_to_q15(ct * sf * 32768);
        e.rot[2] = q45_to_q15(-st * 64'sd1073741824);
        e.rot[3] = q45_to_q15(-cp * sf * 32768 + sp * st * cf);
        e.rot[4] = q45_to_q15(cp * cf * 32768 + sp * st * sf);
        e.rot[5] = q45_to_q15(sp * ct * 32768);
        e.rot[6] = q45_to_q15(sp * sf * 32768 + cp * st * cf);
        e.rot[7] = q45_to_q15(-sp * cf * 32768 + cp * st * sf);
        e.rot[8] = q45_to_q15(cp * ct * 32768);
        e.pos[0] = px;
        e.pos[1] = py;
        e.pos[2] = pz;
        pending.insert(pending.size(), e);
    endfunction

    function void check_result(pose_t got);
        pose_t e;
        bit bad;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("result with no request outstanding");
            return;
        end
        e = pending.pop_front();
        bad = 0;
        foreach (e.rot[i]) if (e.rot[i] !== got.rot[i]) bad = 1;
        foreach (e.pos[i]) if (e.pos[i] !== got.pos[i]) bad = 1;
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected rot %p pos %p, got rot %p pos %p",
                         e.rot, e.pos, got.rot, got.pos);
        end
    endfunction

endclass

module testbench;

    import eapm_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy, done;
    logic signed [POS_W-1:0]   pos_x = 0, pos_y = 0, pos_z = 0;
    logic signed [ANGLE_W-1:0] angle_theta = 0, angle_psi = 0, angle_phi = 0;
    logic signed [ENTRY_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [POS_W-1:0]   out_x, out_y, out_z;

    pose_scoreboard board = new();
    int gap_left = 0;
    bit no_gaps = 0;

    always #5 clk = ~clk;

    euler_angles_to_pose_matrix dut (.*);

    // result monitor
    always @(posedge clk)
    begin
        pose_t got;
        if (rst_n && done)
        begin
            got.rot = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
            got.pos = '{out_x, out_y, out_z};
            board.check_result(got);
        end
    end

    // one request; start stays high into the next one unless a gap follows
    task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [15:0] th, logic [15:0] ps, logic [15:0] ph);
        if (!no_gaps && gap_left == 0 && $urandom_range(0, 9) == 0)
            gap_left = $urandom_range(1, 14);
        if (gap_left > 0)
        begin
            start <= 0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        start <= 1;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        angle_theta <= th; angle_psi <= ps; angle_phi <= ph;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_request(px, py, pz, th, ps, ph);
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_angle();
        logic [15:0] base;
        case ($urandom_range(0, 3))
            0: base = 16'(8192 * $urandom_range(0, 7));
            1: base = 16'(16384 * $urandom_range(0, 3) + 8192 + $urandom_range(0, 2) - 1);
            default: base = 16'($urandom);
        endcase
        return base;
    endfunction

    initial
    begin
        #100_000_000;
        $display("euler_angles_to_pose_matrix regression: fail");
        $finish;
    end

    initial
    begin
        logic [15:0] corner [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                    16'h2000, 16'h7FFF, 16'hFFFF, 16'h2001};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, quadrant edges, octant swap point
        send_pose(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 0, 0, 0);
        send_pose(32'h80000000, 32'h7FFFFFFF, 32'h00000000, 16'h8000, 16'h8000, 16'h8000);
        send_pose(32'h55555555, 32'hAAAAAAAA, 32'h00000001,
                  16'h7FFF, 16'h7FFF, 16'h7FFF);
        for (int i = 0; i < 8; i++)
            send_pose($urandom, $urandom, $urandom, corner[i], corner[(i + 3) % 8],
                      corner[(i + 5) % 8]);
        for (int i = 0; i < 8; i++)
            send_pose($urandom, $urandom, $urandom, corner[(i + 1) % 8], corner[i],
                      corner[7 - i]);

        // hold off until the pipeline has emptied
        drain();

        // random, last part without gaps
        for (int n = 0; n < 800; n++)
        begin
            if (n == 650) no_gaps = 1;
            send_pose($urandom, $urandom, $urandom, rand_angle(), rand_angle(),
                      rand_angle());
        end
        drain();
        repeat (25) @(posedge clk);

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("euler_angles_to_pose_matrix regression: pass");
        else
            $display("euler_angles_to_pose_matrix regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/eapm_pkg.sv
rtl/eapm_sincos.sv
rtl/euler_angles_to_pose_matrix.sv
rtl/eapm_checker.sv
tb/testbench.sv
